// ===== sv/mrm_pkg.sv =====
// Shared types and constants for the register machine execute block.
// No dependencies.
`default_nettype none
package mrm_pkg;
  localparam int MEM_BYTES  = 64;
  localparam int NUM_REGS   = 32;
  localparam int PROG_DEPTH = 1024;
  localparam int MA_W = $clog2(MEM_BYTES);
  localparam int RA_W = $clog2(NUM_REGS);
  localparam int PC_W = $clog2(PROG_DEPTH);
  localparam int QDEPTH = 2;

  localparam logic [3:0] OP_LDR = 4'd0, OP_STR = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
    OP_MOV = 4'd4, OP_MOVZ = 4'd5, OP_MOVK = 4'd6, OP_PRINT = 4'd7, OP_CBZ = 4'd8,
    OP_B = 4'd9, OP_DUMP = 4'd10, OP_HLT = 4'd11;
  localparam logic [1:0] SK_NONE = 2'd0, SK_REG = 2'd1;
  localparam logic [1:0] SH_LSL = 2'd1, SH_LSR = 2'd2;
  localparam logic [1:0] K_DONE = 2'd0, K_PRINT = 2'd1, K_DUMP = 2'd2;

  // Classified instruction handed from front to back.
  typedef struct packed {
    logic [3:0]  opcode;
    logic [4:0]  dest_reg;
    logic        first_is_reg;
    logic [4:0]  first_reg;
    logic [63:0] first_imm;
    logic        use_dest_src;   // ADD/SUB with no second source
    logic        second_is_reg;
    logic [4:0]  second_reg;
    logic [63:0] second_imm;
    logic [1:0]  shift_kind;
    logic [5:0]  shift_amount;
    logic [9:0]  branch_target;
  } instr_t;

  function automatic logic [63:0] shift_op(logic [63:0] v, logic [1:0] k, logic [5:0] a);
    case (k)
      SH_LSL:  shift_op = v << a;
      SH_LSR:  shift_op = v >> a;
      default: shift_op = v;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== sv/mrm_front.sv =====
// Front end: accepts instructions, classifies operands, queues them.
// Depends on mrm_pkg.
`default_nettype none
module mrm_front import mrm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  opcode,
  input  wire logic [4:0]  dest_reg,
  input  wire logic        first_is_reg,
  input  wire logic [4:0]  first_reg,
  input  wire logic [63:0] first_imm,
  input  wire logic [1:0]  second_kind,
  input  wire logic [4:0]  second_reg,
  input  wire logic [63:0] second_imm,
  input  wire logic [1:0]  shift_kind,
  input  wire logic [5:0]  shift_amount,
  input  wire logic [9:0]  branch_target,
  output logic             q_valid,
  output instr_t           q_data,
  input  wire logic        q_pop
);
  instr_t q [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wr_ptr, rd_ptr;
  logic [$clog2(QDEPTH):0]   count;
  logic push;
  instr_t cls;

  assign busy = (count == ($clog2(QDEPTH)+1)'(QDEPTH));
  assign push = start && !busy;
  assign q_valid = (count != '0);
  assign q_data = q[rd_ptr];

  // Classify operand sources
  always_comb begin
    cls.opcode        = opcode;
    cls.dest_reg      = dest_reg;
    cls.first_is_reg  = first_is_reg;
    cls.first_reg     = first_reg;
    cls.first_imm     = first_imm;
    cls.use_dest_src  = (second_kind == SK_NONE);
    cls.second_is_reg = (second_kind == SK_REG);
    cls.second_reg    = second_reg;
    cls.second_imm    = second_imm;
    cls.shift_kind    = shift_kind;
    cls.shift_amount  = shift_amount;
    cls.branch_target = branch_target;
  end

  // Hold queue entries
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end
  end
endmodule
`default_nettype wire

// ===== sv/mrm_back.sv =====
// Back end: register file, data memory, pc and result sequencing.
// Depends on mrm_pkg.
`default_nettype none
module mrm_back import mrm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  instr_t           q_data,
  output logic             q_pop,
  output logic             strobe,
  output logic [1:0]       kind,
  output logic [63:0]      value,
  output logic [5:0]       dump_address,
  output logic [9:0]       next_pc,
  output logic             halted,
  output logic             last
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_OPER, S_EXEC, S_MEM, S_DUMP} state_t;
  state_t state;

  logic [63:0] regs [NUM_REGS];
  logic [7:0]  mem  [MEM_BYTES];
  logic [PC_W-1:0] pc;
  logic halt;
  logic [MA_W:0] clr;

  instr_t ins;
  logic [63:0] op1, op2, rdv;       // registered operands
  logic [63:0] mdata;
  logic [2:0]  bcnt;
  logic [MA_W:0] addr;              // current byte address, in-range only
  logic [63:0] first_v, second_v, dest_v;
  logic in_range;
  logic [63:0] s1, s2, res;
  logic [PC_W-1:0] exec_pc;
  logic exec_mem, exec_dump, exec_wr, seq_end;

  // Operand reads
  always_comb begin
    first_v  = ins.first_is_reg ? regs[ins.first_reg[RA_W-1:0]] : ins.first_imm;
    second_v = ins.second_is_reg ? regs[ins.second_reg[RA_W-1:0]] : ins.second_imm;
    dest_v   = regs[ins.dest_reg[RA_W-1:0]];
  end
  assign in_range = (op1 < 64'(MEM_BYTES));

  // ALU on registered operands; a load beyond memory writes zero
  always_comb begin
    s1 = ins.use_dest_src ? rdv : op1;
    s2 = shift_op(ins.use_dest_src ? op1 : op2, ins.shift_kind, ins.shift_amount);
    case (ins.opcode)
      OP_LDR:  res = '0;
      OP_ADD:  res = s1 + s2;
      OP_SUB:  res = s1 - s2;
      OP_MOVK: res = rdv + shift_op(op1, ins.shift_kind, ins.shift_amount);
      default: res = op1;
    endcase
  end

  // Decide next pc, register write and follow-on state for the execute step
  always_comb begin
    exec_pc = pc + 1'b1;
    if (ins.opcode == OP_B || (ins.opcode == OP_CBZ && rdv == 64'd0))
      exec_pc = ins.branch_target[PC_W-1:0];
    exec_mem  = (ins.opcode == OP_LDR || ins.opcode == OP_STR) && in_range;
    exec_dump = (ins.opcode == OP_DUMP) && in_range;
    case (ins.opcode)
      OP_LDR:  exec_wr = !in_range;
      OP_ADD, OP_SUB, OP_MOV, OP_MOVZ, OP_MOVK: exec_wr = 1'b1;
      default: exec_wr = 1'b0;
    endcase
    seq_end = (bcnt == 3'd7) || (addr == (MA_W+1)'(MEM_BYTES-1));
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // Sequence each instruction; hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      pc <= '0;
      halt <= 1'b0;
      strobe <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          // Clear memory one byte a cycle; reset register file on the first ones
          strobe <= 1'b0;
          mem[clr[MA_W-1:0]] <= 8'h00;
          if (clr < (MA_W+1)'(NUM_REGS))
            regs[clr[RA_W-1:0]] <= (clr == (MA_W+1)'(NUM_REGS-1)) ? 64'(MEM_BYTES) : 64'd0;
          clr <= clr + 1'b1;
          if (clr == (MA_W+1)'(MEM_BYTES-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          strobe <= 1'b0;
          if (q_valid) begin
            ins <= q_data;
            state <= S_OPER;
          end
        end
        S_OPER: begin
          op1 <= first_v;
          op2 <= second_v;
          rdv <= dest_v;
          strobe <= halt;
          if (halt) begin
            kind <= K_DONE; value <= '0; dump_address <= '0;
            next_pc <= 10'(pc); halted <= 1'b1; last <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          addr <= op1[MA_W:0];
          bcnt <= '0;
          mdata <= '0;
          kind <= (ins.opcode == OP_PRINT) ? K_PRINT : K_DONE;
          value <= (ins.opcode == OP_PRINT) ? rdv : 64'd0;
          dump_address <= '0;
          last <= 1'b1;
          halted <= halt || (ins.opcode == OP_HLT);
          next_pc <= 10'(exec_pc);
          pc <= exec_pc;
          if (ins.opcode == OP_HLT) halt <= 1'b1;
          if (exec_wr) regs[ins.dest_reg[RA_W-1:0]] <= res;
          strobe <= !(exec_mem || exec_dump);
          if (exec_mem) state <= S_MEM;
          else if (exec_dump) state <= S_DUMP;
          else state <= S_IDLE;
        end
        S_MEM: begin
          // One byte a cycle, stop after eight bytes or at the end of memory
          if (ins.opcode == OP_STR)
            mem[addr[MA_W-1:0]] <= rdv[8*bcnt +: 8];
          else
            mdata[8*bcnt +: 8] <= mem[addr[MA_W-1:0]];
          addr <= addr + 1'b1;
          bcnt <= bcnt + 1'b1;
          strobe <= seq_end;
          if (seq_end) begin
            if (ins.opcode == OP_LDR)
              regs[ins.dest_reg[RA_W-1:0]] <=
                mdata | (64'(mem[addr[MA_W-1:0]]) << {bcnt, 3'b000});
            state <= S_IDLE;
          end
        end
        S_DUMP: begin
          strobe <= 1'b1;
          kind <= K_DUMP;
          value <= 64'(mem[addr[MA_W-1:0]]);
          dump_address <= 6'(addr);
          last <= seq_end;
          addr <= addr + 1'b1;
          bcnt <= bcnt + 1'b1;
          if (seq_end) state <= S_IDLE;
        end
        default: begin
          strobe <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/mini_register_machine_execute_top.sv =====
// Execute block of a small register machine: front queue plus back sequencer.
// The back end pops an instruction, registers its operands, executes it and strobes the
// result; halted, it strobes after the operand read. LDR/STR first move each in-range byte
// (up to 8) in turn; DUMP strobes its in-range bytes on consecutive cycles. Pops wait
// until the last instruction is done; a two-entry queue decouples the front. Reset:
// synchronous; a pass then clears memory and all registers but r31 (set to 64); meanwhile
// up to two transactions queue and busy holds off the rest. The receiver cannot stall.
`default_nettype none
module mini_register_machine_execute_top import mrm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  opcode,
  input  wire logic [4:0]  dest_reg,
  input  wire logic        first_is_reg,
  input  wire logic [4:0]  first_reg,
  input  wire logic [63:0] first_imm,
  input  wire logic [1:0]  second_kind,
  input  wire logic [4:0]  second_reg,
  input  wire logic [63:0] second_imm,
  input  wire logic [1:0]  shift_kind,
  input  wire logic [5:0]  shift_amount,
  input  wire logic [9:0]  branch_target,
  output logic             strobe,
  output logic [1:0]       kind,
  output logic [63:0]      value,
  output logic [5:0]       dump_address,
  output logic [9:0]       next_pc,
  output logic             halted,
  output logic             last
);
  logic q_valid, q_pop;
  instr_t q_data;

  mrm_front u_front (.clk, .rst, .start, .busy, .opcode, .dest_reg, .first_is_reg,
    .first_reg, .first_imm, .second_kind, .second_reg, .second_imm, .shift_kind,
    .shift_amount, .branch_target, .q_valid, .q_data, .q_pop);

  mrm_back u_back (.clk, .rst, .q_valid, .q_data, .q_pop, .strobe, .kind, .value,
    .dump_address, .next_pc, .halted, .last);
endmodule
`default_nettype wire

// ===== sv/mrm_checker.sv =====
// Port-level checks for the execute block, bound to the top level.
// Depends on mrm_pkg and mini_register_machine_execute_top.
`default_nettype none
module mrm_checker import mrm_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       strobe,
  input wire logic [1:0] kind,
  input wire logic [63:0] value,
  input wire logic [5:0] dump_address,
  input wire logic       halted,
  input wire logic       last
);
  // Halt stays set once reported
  a_halt: assert property (@(posedge clk) disable iff (rst)
    strobe && halted |=> !strobe || halted) else $error("halt cleared");
  // Non-dump results are single and final
  a_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind != K_DUMP |-> last) else $error("non-dump not last");
  // Step results carry zero payload
  a_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == K_DONE |-> value == 64'd0 && dump_address == 6'd0)
    else $error("step payload");
  // Dumped bytes fit in a byte
  a_byte: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == K_DUMP |-> value[63:8] == 56'd0) else $error("dump width");
endmodule

bind mini_register_machine_execute_top mrm_checker u_chk (.clk, .rst, .strobe, .kind,
  .value, .dump_address, .halted, .last);
`default_nettype wire

// ===== verif/mini_register_machine_execute_checker.sv =====
`timescale 1ns / 100ps
// Prediction and comparison for the register machine execute block.
// Depends on mrm_pkg; watches the start/busy and strobe channels of the block.
`default_nettype none
module mini_register_machine_execute_checker import mrm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [3:0]  opcode,
  input  wire logic [4:0]  dest_reg,
  input  wire logic        first_is_reg,
  input  wire logic [4:0]  first_reg,
  input  wire logic [63:0] first_imm,
  input  wire logic [1:0]  second_kind,
  input  wire logic [4:0]  second_reg,
  input  wire logic [63:0] second_imm,
  input  wire logic [1:0]  shift_kind,
  input  wire logic [5:0]  shift_amount,
  input  wire logic [9:0]  branch_target,
  input  wire logic        strobe,
  input  wire logic [1:0]  kind,
  input  wire logic [63:0] value,
  input  wire logic [5:0]  dump_address,
  input  wire logic [9:0]  next_pc,
  input  wire logic        halted,
  input  wire logic        last,
  output int               errors,
  output int               pending
);

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] value;
    logic [5:0]  dump_address;
    logic [9:0]  next_pc;
    logic        halted;
    logic        last;
  } machine_result_t;

  machine_result_t awaited_results[$];
  logic [63:0] shadow_regs[NUM_REGS];
  logic [7:0]  shadow_mem[MEM_BYTES];
  logic [9:0]  shadow_pc;
  logic        shadow_halt;

  function automatic logic [63:0] apply_shift(logic [63:0] v, logic [1:0] k, logic [5:0] a);
    if (k == SH_LSL) return v << a;
    if (k == SH_LSR) return v >> a;
    return v;
  endfunction

  function automatic logic [63:0] load_word(logic [63:0] addr);
    logic [63:0] w;
    w = '0;
    if (addr < MEM_BYTES)
      for (int i = 0; i < 8; i++)
        if (addr + i < MEM_BYTES) w[8*i +: 8] = shadow_mem[MA_W'(addr + i)];
    return w;
  endfunction

  function automatic void queue_result(logic [1:0] k, logic [63:0] v, logic [5:0] a,
                                       logic l);
    machine_result_t r;
    r.kind = k;
    r.value = v;
    r.dump_address = a;
    r.next_pc = shadow_pc;
    r.halted = shadow_halt;
    r.last = l;
    awaited_results = {awaited_results, r};
  endfunction

  // Run one instruction on the shadow state and queue the results it causes.
  function automatic void execute_instruction();
    logic [63:0] first, second, s1, s2, rdv;
    logic [9:0]  npc;
    rdv = shadow_regs[dest_reg];
    first = first_is_reg ? shadow_regs[first_reg] : first_imm;
    second = (second_kind == SK_REG) ? shadow_regs[second_reg] : second_imm;
    npc = shadow_pc + 10'd1;
    if (shadow_halt) begin
      queue_result(K_DONE, '0, '0, 1'b1);
      return;
    end
    case (opcode)
      OP_LDR: shadow_regs[dest_reg] = load_word(first);
      OP_STR: begin
        if (first < MEM_BYTES)
          for (int i = 0; i < 8; i++)
            if (first + i < MEM_BYTES) shadow_mem[MA_W'(first + i)] = rdv[8*i +: 8];
      end
      OP_ADD, OP_SUB: begin
        if (second_kind == SK_NONE) begin
          s1 = rdv;
          s2 = first;
        end else begin
          s1 = first;
          s2 = second;
        end
        s2 = apply_shift(s2, shift_kind, shift_amount);
        shadow_regs[dest_reg] = (opcode == OP_ADD) ? s1 + s2 : s1 - s2;
      end
      OP_MOV, OP_MOVZ: shadow_regs[dest_reg] = first;
      OP_MOVK: shadow_regs[dest_reg] = rdv + apply_shift(first, shift_kind, shift_amount);
      OP_CBZ: if (rdv == 0) npc = branch_target;
      OP_B: npc = branch_target;
      OP_HLT: shadow_halt = 1'b1;
      default: ;
    endcase
    shadow_pc = npc;
    if (opcode == OP_PRINT) begin
      queue_result(K_PRINT, shadow_regs[dest_reg], '0, 1'b1);
    end else if (opcode == OP_DUMP && first < MEM_BYTES) begin
      for (int i = 0; i < 8 && first + i < MEM_BYTES; i++)
        queue_result(K_DUMP, {56'd0, shadow_mem[MA_W'(first + i)]}, 6'(first + i),
                     (i == 7) || (first + i == MEM_BYTES - 1));
    end else begin
      queue_result(K_DONE, '0, '0, 1'b1);
    end
  endfunction

  // Predict on each accepted transaction, then compare each strobed result.
  always @(posedge clk) begin
    machine_result_t exp_r;
    if (rst) begin
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      shadow_regs[NUM_REGS-1] = 64'(MEM_BYTES);
      shadow_pc = '0;
      shadow_halt = 1'b0;
      awaited_results.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (start && !busy) execute_instruction();
      if (strobe) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d value=%h", $time, kind, value);
          errors++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (kind !== exp_r.kind || value !== exp_r.value ||
              dump_address !== exp_r.dump_address || next_pc !== exp_r.next_pc ||
              halted !== exp_r.halted || last !== exp_r.last) begin
            $display("%0t: mismatch expected kind=%0d value=%h addr=%0d pc=%0d halt=%b last=%b",
                     $time, exp_r.kind, exp_r.value, exp_r.dump_address, exp_r.next_pc,
                     exp_r.halted, exp_r.last);
            $display("%0t:          actual kind=%0d value=%h addr=%0d pc=%0d halt=%b last=%b",
                     $time, kind, value, dump_address, next_pc, halted, last);
            errors++;
          end
        end
      end
      pending = awaited_results.size();
    end
  end
endmodule
`default_nettype wire

// ===== verif/mini_register_machine_execute_top_test.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the register machine execute block.
// Depends on mrm_pkg, mini_register_machine_execute_top and the checker module.
`default_nettype none
module mini_register_machine_execute_top_test;
  import mrm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 135;

  typedef struct {
    logic [3:0]  op;
    logic [4:0]  rd;
    logic        fir;
    logic [4:0]  fr;
    logic [63:0] fi;
    logic [1:0]  sk;
    logic [4:0]  sr;
    logic [63:0] si;
    logic [1:0]  shk;
    logic [5:0]  sha;
    logic [9:0]  bt;
  } instr_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] opcode = '0;
  logic [4:0] dest_reg = '0, first_reg = '0, second_reg = '0;
  logic first_is_reg = 1'b0;
  logic [63:0] first_imm = '0, second_imm = '0;
  logic [1:0] second_kind = '0, shift_kind = '0;
  logic [5:0] shift_amount = '0;
  logic [9:0] branch_target = '0;
  logic busy, strobe, halted, last;
  logic [1:0] kind;
  logic [63:0] value;
  logic [5:0] dump_address;
  logic [9:0] next_pc;
  int errors, pending;
  int cycle_count = 0;

  mini_register_machine_execute_top u_top (.*);
  mini_register_machine_execute_checker u_checker (.*);

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic instr_item_t mk(logic [3:0] op, logic [4:0] rd, logic fir,
      logic [4:0] fr, logic [63:0] fi, logic [1:0] sk, logic [4:0] sr, logic [63:0] si,
      logic [1:0] shk, logic [5:0] sha, logic [9:0] bt);
    instr_item_t it;
    it = '{op, rd, fir, fr, fi, sk, sr, si, shk, sha, bt};
    return it;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 72));
      1: return 64'($urandom_range(0, 1)) ? '1 : '0;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random instruction, HLT left out; addresses lean toward the memory window.
  function automatic instr_item_t rand_instr();
    instr_item_t it;
    logic [3:0] ops[$] = '{OP_LDR, OP_STR, OP_ADD, OP_SUB, OP_MOV, OP_MOVZ, OP_MOVK,
                           OP_PRINT, OP_CBZ, OP_B, OP_DUMP};
    it.op = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(12, 15))
                                         : ops[$urandom_range(0, ops.size() - 1)];
    it.rd = 5'($urandom_range(0, 31));
    it.fir = $urandom_range(0, 2) == 0;
    it.fr = 5'($urandom_range(0, 31));
    it.fi = rand_word();
    if ((it.op == OP_LDR || it.op == OP_STR || it.op == OP_DUMP) &&
        $urandom_range(0, 3) != 0)
      it.fi = 64'($urandom_range(0, 70));
    it.sk = 2'($urandom_range(0, 3));
    it.sr = 5'($urandom_range(0, 31));
    it.si = rand_word();
    it.shk = 2'($urandom_range(0, 3));
    it.sha = 6'($urandom_range(0, 63));
    it.bt = 10'($urandom_range(0, 1023));
    return it;
  endfunction

  // Hold the transaction until the block takes it; return at the next falling edge.
  task automatic send(instr_item_t it);
    opcode <= it.op;
    dest_reg <= it.rd;
    first_is_reg <= it.fir;
    first_reg <= it.fr;
    first_imm <= it.fi;
    second_kind <= it.sk;
    second_reg <= it.sr;
    second_imm <= it.si;
    shift_kind <= it.shk;
    shift_amount <= it.sha;
    branch_target <= it.bt;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_gap(bit bursty);
    int n;
    n = bursty ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 2));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    instr_item_t directed[$];
    bit bursty;
    directed = '{
      mk(OP_MOV, 0, 0, 0, '1, 0, 0, 0, 0, 0, 0),
      mk(OP_MOVZ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_ADD, 2, 1, 0, 0, SK_NONE, 0, 0, SH_LSL, 0, 0),
      mk(OP_ADD, 3, 1, 31, 0, SK_REG, 0, 0, SH_LSL, 63, 0),
      mk(OP_SUB, 4, 0, 0, 0, 2'd2, 0, '1, SH_LSR, 63, 0),
      mk(OP_SUB, 5, 0, 0, 5, 2'd3, 0, 64'd7, 2'd3, 1, 0),
      mk(OP_MOVK, 5, 0, 0, 64'hFFFF, 0, 0, 0, SH_LSL, 48, 0),
      mk(OP_STR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_STR, 5, 0, 0, 60, 0, 0, 0, 0, 0, 0),
      mk(OP_STR, 0, 0, 0, 64, 0, 0, 0, 0, 0, 0),
      mk(OP_LDR, 6, 0, 0, 58, 0, 0, 0, 0, 0, 0),
      mk(OP_LDR, 7, 1, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_PRINT, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_PRINT, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_DUMP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(OP_DUMP, 0, 0, 0, 60, 0, 0, 0, 0, 0, 0),
      mk(OP_DUMP, 0, 0, 0, 100, 0, 0, 0, 0, 0, 0),
      mk(OP_CBZ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 10'd1023),
      mk(OP_CBZ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10'd5),
      mk(OP_B, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10'd1023),
      mk(4'd13, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      send(directed[i]);
      idle_gap(1'b0);
    end
    drain();
    // Random part: gapped and back-to-back stretches, chosen at random.
    bursty = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) bursty = 1'($urandom_range(0, 1));
      if (i == RANDOM_ITEMS / 2) drain();
      send(rand_instr());
      idle_gap(bursty);
    end
    // Halt last, then show that later instructions are ignored.
    send(mk(OP_HLT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_MOV, 0, 0, 0, 64'd9, 0, 0, 0, 0, 0, 0));
    send(mk(OP_DUMP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_PRINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/mrm_pkg.sv
sv/mrm_front.sv
sv/mrm_back.sv
sv/mini_register_machine_execute_top.sv
sv/mrm_checker.sv
verif/mini_register_machine_execute_checker.sv
verif/mini_register_machine_execute_top_test.sv
